@@ src/rbdq_pkg.sv @@
// Package with the shared types and constants of the ring buffer deque.
`default_nettype none
package rbdq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 11;
    localparam int OPCODE_W      = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_REAR  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_HEAD   = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_opcode;

    typedef struct packed {
        logic rd_used;
        logic was_empty;
        logic push_dropped;
        logic is_empty;
        logic is_full;
    } t_result_flags;

endpackage
`default_nettype wire

@@ src/rbdq_store.sv @@
// Entry store of the deque: one write port and one registered read port.
`default_nettype none
module rbdq_store
    import rbdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [IDX_W-1:0]  i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [IDX_W-1:0]  i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ src/rbdq_ctrl.sv @@
// Index, occupancy and result control of the deque.
`default_nettype none
module rbdq_ctrl
    import rbdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int OCC_W = $clog2(DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [DATA_W-1:0]   i_value,
    output logic                     o_busy,
    output logic                     o_we,
    output logic      [IDX_W-1:0]    o_waddr,
    output logic      [DATA_W-1:0]   o_wdata,
    output logic                     o_re,
    output logic      [IDX_W-1:0]    o_raddr,
    output logic                     o_valid,
    output t_result_flags            o_flags,
    output logic      [COUNT_W-1:0]  o_count
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    logic              r_busy;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic              r_empty, n_empty;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic              r_valid;
    t_result_flags     r_flags, n_flags;
    logic [COUNT_W-1:0] r_count;
    logic              accept;
    logic              full;
    logic              at_front;
    t_opcode           op;

    assign accept = i_start && !r_busy;
    assign full   = (r_occ == FULL_OCC);
    assign op     = t_opcode'(i_opcode);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_occ    = r_occ;
        n_flags  = '0;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = i_value;
        o_re     = 1'b0;
        o_raddr  = r_head;
        at_front = 1'b0;
        if (accept) begin
            case (op)
                OP_PUSH_REAR, OP_PUSH_FRONT: begin
                    if (full) begin
                        n_flags.push_dropped = 1'b1;
                    end else begin
                        o_we  = 1'b1;
                        n_occ = r_occ + 1'b1;
                        if (r_empty) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_empty = 1'b0;
                            o_waddr = '0;
                        end else if (op == OP_PUSH_REAR) begin
                            n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                            o_waddr = n_tail;
                        end else begin
                            n_head  = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
                            o_waddr = n_head;
                        end
                    end
                end
                OP_POP_HEAD, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                    if (r_empty) begin
                        n_flags.was_empty = 1'b1;
                    end else begin
                        at_front        = (op == OP_POP_HEAD) || (op == OP_PEEK_FRONT);
                        o_re            = 1'b1;
                        o_raddr         = at_front ? r_head : r_tail;
                        n_flags.rd_used = 1'b1;
                        if (op == OP_POP_HEAD || op == OP_POP_BACK) begin
                            if (r_head == r_tail) begin
                                n_head  = '0;
                                n_tail  = '0;
                                n_empty = 1'b1;
                                n_occ   = '0;
                            end else begin
                                if (at_front) begin
                                    n_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                                end else begin
                                    n_tail = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
                                end
                                n_occ = r_occ - 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_flags.is_empty = n_empty;
        n_flags.is_full  = (n_occ == FULL_OCC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_occ   <= n_occ;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flags <= n_flags;
            r_count <= COUNT_W'(n_occ);
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_count = r_count;

`ifndef ASSERT_OFF
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL_OCC)
        else $error("occupancy exceeds depth");
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty == (r_occ == '0))
        else $error("empty mark disagrees with occupancy");
    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0))
        else $error("indices not at zero while empty");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("accepted item gave no result");
    a_no_access_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("write and read in the same item");
`endif

endmodule
`default_nettype wire

@@ src/ring_buffer_deque.sv @@
// Top level of the ring buffer deque.
// An item (opcode and value) is accepted at a rising edge where start is high
// and busy is low. Opcodes: push back, push front, pop front, pop back, peek
// front, peek back; the two unused codes change nothing and still give a result.
// Every item gives exactly one result, shown for one cycle with o_valid high,
// in the cycle after the item is accepted. The receiver cannot stall.
// A new item may be accepted in every cycle while busy is low, so the rate is one item a cycle.
// The read word is registered in the read port of the entry
// store; pushes write the store in the cycle they are accepted, so a later pop
// of the same entry reads the new word without forwarding.
// The result carries the word read (0 on push, unused code or empty access), the empty
// access and dropped push flags, and the count, empty and full status after
// the operation. Count is the occupancy taken to its 11-bit field.
// Reset is synchronous and active low; it empties the deque and holds busy
// high for one cycle after reset is released. The store needs no clearing.
`default_nettype none
module ring_buffer_deque
    import rbdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic        [OPCODE_W-1:0] i_opcode,
    input  wire logic signed [DATA_W-1:0]   i_value,
    output logic                           o_valid,
    output logic signed      [DATA_W-1:0]   o_read_value,
    output logic                           o_was_empty,
    output logic                           o_push_dropped,
    output logic             [COUNT_W-1:0]  o_count,
    output logic                           o_is_empty,
    output logic                           o_is_full
);

    localparam int IDX_W = $clog2(DEPTH);

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;
    t_result_flags     flags;

    rbdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_value  (i_value),
        .o_busy   (busy),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_re     (re),
        .o_raddr  (raddr),
        .o_valid  (o_valid),
        .o_flags  (flags),
        .o_count  (o_count)
    );

    rbdq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_read_value   = flags.rd_used ? $signed(rdata) : '0;
    assign o_was_empty    = flags.was_empty;
    assign o_push_dropped = flags.push_dropped;
    assign o_is_empty     = flags.is_empty;
    assign o_is_full      = flags.is_full;

endmodule
`default_nettype wire

@@ verif/tb_ring_buffer_deque.sv @@
// Self-checking testbench for the ring buffer deque: directed table, then biased random items.
`default_nettype none
module tb_ring_buffer_deque;
    import rbdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int DIR_ROWS    = 23;
    localparam int TOTAL_ITEMS = 1575;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]  read_value;
        logic               was_empty;
        logic               push_dropped;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
    } t_dq_result;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [DATA_W-1:0]   value;
        logic                typed;
        t_dq_result          result;
    } t_stim_row;

    logic                       i_clk    = 1'b0;
    logic                       i_rst_n  = 1'b0;
    logic                       start    = 1'b0;
    logic        [OPCODE_W-1:0] i_opcode = '0;
    logic signed [DATA_W-1:0]   i_value  = '0;
    logic                       busy;
    logic                       o_valid;
    logic signed [DATA_W-1:0]   o_read_value;
    logic                       o_was_empty;
    logic                       o_push_dropped;
    logic        [COUNT_W-1:0]  o_count;
    logic                       o_is_empty;
    logic                       o_is_full;

    logic [DATA_W-1:0] shadow_store [DEPTH];
    int unsigned       front_idx    = 0;
    int unsigned       rear_idx     = 0;
    int unsigned       held         = 0;
    bit                shadow_empty = 1'b1;

    t_dq_result deque_expect_q [$];
    t_stim_row  dir_table [DIR_ROWS];
    int         errors     = 0;
    int         items_sent = 0;
    int         burst_left = 0;

    ring_buffer_deque #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_was_empty   (o_was_empty),
        .o_push_dropped(o_push_dropped),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_dq_result deque_apply(input logic [OPCODE_W-1:0] op,
                                               input logic [DATA_W-1:0] word);
        t_dq_result  res;
        int unsigned where;
        res = '0;
        case (op)
            OP_PUSH_REAR, OP_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    res.push_dropped = 1'b1;
                end else begin
                    if (shadow_empty) begin
                        front_idx = 0;
                        rear_idx = 0;
                        shadow_empty = 1'b0;
                        shadow_store[0] = word;
                    end else if (op == OP_PUSH_REAR) begin
                        rear_idx = (rear_idx + 1) % DEPTH;
                        shadow_store[rear_idx] = word;
                    end else begin
                        front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
                        shadow_store[front_idx] = word;
                    end
                    held++;
                end
            end
            OP_POP_HEAD, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (shadow_empty) begin
                    res.was_empty = 1'b1;
                end else begin
                    where = (op == OP_POP_HEAD || op == OP_PEEK_FRONT) ? front_idx : rear_idx;
                    res.read_value = shadow_store[where];
                    if (op == OP_POP_HEAD || op == OP_POP_BACK) begin
                        if (front_idx == rear_idx) begin
                            shadow_empty = 1'b1;
                            front_idx = 0;
                            rear_idx = 0;
                            held = 0;
                        end else begin
                            if (op == OP_POP_HEAD)
                                front_idx = (front_idx + 1) % DEPTH;
                            else
                                rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
                            held--;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.count    = COUNT_W'(held);
        res.is_empty = shadow_empty;
        res.is_full  = (held >= DEPTH);
        return res;
    endfunction

    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return ($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
        if (roll < 2 + push_pct)
            return ($urandom_range(0, 1) == 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        case ($urandom_range(0, 3))
            0:       return OP_POP_HEAD;
            1:       return OP_POP_BACK;
            2:       return OP_PEEK_FRONT;
            default: return OP_PEEK_BACK;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue_item(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] word,
                              input logic typed, input t_dq_result typed_res);
        int         gap;
        t_dq_result predicted;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_opcode <= op;
        i_value  <= word;
        do @(posedge i_clk); while (busy);
        predicted = deque_apply(op, word);
        deque_expect_q.insert(deque_expect_q.size(), typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic issue_random(input int push_pct);
        issue_item(pick_op(push_pct), pick_word(), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_dq_result want;
        if (i_rst_n && o_valid) begin
            if (deque_expect_q.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, actual count %0d",
                         $time, o_count);
                errors++;
            end else begin
                want = deque_expect_q[0];
                deque_expect_q.delete(0);
                check_field("read_value", want.read_value, o_read_value);
                check_field("was_empty", DATA_W'(want.was_empty), DATA_W'(o_was_empty));
                check_field("push_dropped", DATA_W'(want.push_dropped),
                            DATA_W'(o_push_dropped));
                check_field("count", DATA_W'(want.count), DATA_W'(o_count));
                check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(o_is_empty));
                check_field("is_full", DATA_W'(want.is_full), DATA_W'(o_is_full));
            end
        end
    end

    initial begin
        dir_table = '{
            '{OP_POP_HEAD,   32'h0000_0000, 1'b1, '{32'h0, 1'b1, 1'b0, 11'd0, 1'b1, 1'b0}},
            '{OP_POP_BACK,   32'h1234_5678, 1'b1, '{32'h0, 1'b1, 1'b0, 11'd0, 1'b1, 1'b0}},
            '{OP_PEEK_FRONT, 32'hffff_ffff, 1'b1, '{32'h0, 1'b1, 1'b0, 11'd0, 1'b1, 1'b0}},
            '{OP_PEEK_BACK,  32'h8000_0000, 1'b1, '{32'h0, 1'b1, 1'b0, 11'd0, 1'b1, 1'b0}},
            '{OP_UNUSED_6,   32'h7fff_ffff, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 1'b1, 1'b0}},
            '{OP_UNUSED_7,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 1'b1, 1'b0}},
            '{OP_PUSH_REAR,  32'h7fff_ffff, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd1, 1'b0, 1'b0}},
            '{OP_POP_HEAD,   32'h0000_0000, 1'b1,
              '{32'h7fff_ffff, 1'b0, 1'b0, 11'd0, 1'b1, 1'b0}},
            '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd1, 1'b0, 1'b0}},
            '{OP_PEEK_BACK,  32'h0000_0000, 1'b1,
              '{32'h8000_0000, 1'b0, 1'b0, 11'd1, 1'b0, 1'b0}},
            '{OP_PUSH_REAR,  32'hffff_ffff, 1'b0, '0},
            '{OP_PUSH_FRONT, 32'h0000_0000, 1'b0, '0},
            '{OP_PUSH_FRONT, 32'ha5a5_a5a5, 1'b0, '0},
            '{OP_PEEK_FRONT, 32'h0000_0000, 1'b0, '0},
            '{OP_PEEK_BACK,  32'hffff_ffff, 1'b0, '0},
            '{OP_UNUSED_6,   32'h5555_5555, 1'b0, '0},
            '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
            '{OP_POP_HEAD,   32'h0000_0000, 1'b0, '0},
            '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
            '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
            '{OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0, 1'b1, 1'b0, 11'd0, 1'b1, 1'b0}},
            '{OP_PUSH_FRONT, 32'h5a5a_5a5a, 1'b0, '0},
            '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            issue_item(dir_table[i].opcode, dir_table[i].value, dir_table[i].typed,
                       dir_table[i].result);
        end

        // Walk around the empty state, fill to the top, linger at full, then favour pops up to the item total.
        repeat (150) issue_random(45);
        while (held < DEPTH) issue_random(95);
        repeat (40) issue_random(60);
        while (items_sent < TOTAL_ITEMS) issue_random(25);

        start <= 1'b0;
        while (deque_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (errors == 0)
            $display("ring_buffer_deque regression: pass");
        else
            $display("ring_buffer_deque regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("ring_buffer_deque regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
